// ===== rtl/atv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package atv_pkg;

	localparam int IN_W     = 16;
	localparam int DELTA_W  = 17;
	localparam int MAG_W    = 17;
	localparam int ROLL_W   = 16;
	localparam int PITCH_W  = 15;
	localparam int SUM_W    = 24;
	localparam int PROD_W   = 33;
	localparam int ACC_W    = 35;
	localparam int RAD_W    = 48;
	localparam int ROOT_W   = 24;
	localparam int XY_W     = 28;
	localparam int Z_W      = 26;
	localparam int CORDIC_ITERS = 20;
	localparam int ITER_W   = 5;
	localparam logic signed [Z_W-1:0] Z_90 = 26'sd5898240;

	typedef enum logic [3:0] {
		S_IDLE, S_CAL, S_DIV_GO, S_DIV_WAIT, S_SQ, S_MAG_GO, S_MAG_WAIT,
		S_ROLL_GO, S_ROLL_WAIT, S_NSQ, S_NORM_GO, S_NORM_WAIT,
		S_PITCH_GO, S_PITCH_WAIT, S_DONE
	} atv_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Arctangent of 2^-i in Q16 degrees.
	function automatic logic [21:0] atan_q16(input logic [ITER_W-1:0] i);
		logic [21:0] a;
		case (i)
			5'd0: a = 22'd2949120;
			5'd1: a = 22'd1740967;
			5'd2: a = 22'd919879;
			5'd3: a = 22'd466945;
			5'd4: a = 22'd234379;
			5'd5: a = 22'd117304;
			5'd6: a = 22'd58666;
			5'd7: a = 22'd29335;
			5'd8: a = 22'd14668;
			5'd9: a = 22'd7334;
			5'd10: a = 22'd3667;
			5'd11: a = 22'd1833;
			5'd12: a = 22'd917;
			5'd13: a = 22'd458;
			5'd14: a = 22'd229;
			5'd15: a = 22'd115;
			5'd16: a = 22'd57;
			5'd17: a = 22'd29;
			5'd18: a = 22'd14;
			5'd19: a = 22'd7;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/atv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface atv_sample_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [15:0]       acc_x;
	logic signed [15:0]       acc_y;
	logic signed [15:0]       acc_z;
	modport source (output valid, opcode, acc_x, acc_y, acc_z, input ready);
	modport sink (input valid, opcode, acc_x, acc_y, acc_z, output ready);
endinterface

interface atv_result_if;
	logic                     valid;
	logic                     ready;
	logic signed [16:0]       delta_x;
	logic signed [16:0]       delta_y;
	logic signed [16:0]       delta_z;
	logic [16:0]              magnitude;
	logic signed [15:0]       roll_angle;
	logic signed [14:0]       pitch_angle;
	logic                     is_calibrated;
	modport source (output valid, delta_x, delta_y, delta_z, magnitude, roll_angle,
		pitch_angle, is_calibrated, input ready);
	modport sink (input valid, delta_x, delta_y, delta_z, magnitude, roll_angle,
		pitch_angle, is_calibrated, output ready);
endinterface
`default_nettype wire

// ===== rtl/atv_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atv_div #(
	parameter int DIVISOR = 100
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [atv_pkg::SUM_W-1:0]   dividend,
	output logic [atv_pkg::SUM_W-1:0]        quotient,
	output atv_pkg::unit_stat_t              stat
);
	import atv_pkg::*;

	localparam int DW = $clog2(DIVISOR + 1);
	localparam int PW = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((1 << SUM_W) / DIVISOR);

	logic [SUM_W-1:0]    dvd_q;
	logic [SUM_W-1:0]    quo_q;
	logic [PW-1:0]       prod_q;
	logic [SUM_W+DW-1:0] back_q;
	logic [1:0]          cnt_q;
	logic                busy_q, done_q;
	logic [SUM_W+DW-1:0] diff;

	// Multiply by the truncated reciprocal of the divisor. The estimate is at most one
	// below the true quotient, so one compare of the remainder finishes the job.
	assign diff = (SUM_W+DW)'(dvd_q) - back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end else if (busy_q) begin
			case (cnt_q)
				2'd0: prod_q <= {{(SUM_W+1){1'b0}}, dvd_q} * {{SUM_W{1'b0}}, RECIP};
				2'd1: quo_q <= prod_q[SUM_W +: SUM_W];
				2'd2: back_q <= {{DW{1'b0}}, quo_q} * (SUM_W+DW)'(DIVISOR);
				2'd3: quo_q <= quo_q + SUM_W'(diff >= (SUM_W+DW)'(DIVISOR));
				default: quo_q <= quo_q;
			endcase
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

// ===== rtl/atv_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atv_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [atv_pkg::RAD_W-1:0]   radicand,
	output logic [atv_pkg::ROOT_W-1:0]       root,
	output atv_pkg::unit_stat_t              stat
);
	import atv_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q, done_q;
	logic [ROOT_W+2:0] rem_sh, trial;
	logic              take;

	// Digit-by-digit square root, one root bit per cycle.
	assign rem_sh = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	// The remainder is v - root^2; round up when it exceeds root.
	assign root      = root_q + ROOT_W'(rem_q > {3'b000, root_q});
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

// ===== rtl/atv_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atv_cordic (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [atv_pkg::XY_W-1:0]   y_in,
	input  wire logic signed [atv_pkg::XY_W-1:0]   x_in,
	output logic signed [atv_pkg::Z_W-1:0]         z_out,
	output atv_pkg::unit_stat_t                    stat
);
	import atv_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   zero_q;
	logic [ITER_W-1:0]      i_q;
	logic                   busy_q, done_q;
	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W-1:0]  at;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({4'b0000, atan_q16(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			// A vector in the left half plane is first turned by 90 degrees.
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= y_in;
					y_q <= -x_in;
					z_q <= Z_90;
				end else begin
					x_q <= -y_in;
					y_q <= x_in;
					z_q <= -Z_90;
				end
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign z_out     = zero_q ? '0 : z_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

// ===== rtl/accel_tilt_vibration.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload                                                  | Moves
// sample   | in  | opcode, acc_x, acc_y, acc_z                              | one item per sample
// result   | out | delta_x/y/z, magnitude, roll_angle, pitch_angle,         | one item per
//          |     | is_calibrated                                            | measure sample
//
// A measure item runs from its accepting edge to result.valid through a squarer pass
// over the deltas, the magnitude root, the roll CORDIC, a squarer pass over Y and Z,
// the norm root, the pitch CORDIC and the output register load; the next item is taken
// once the sequencer is back in idle. A calibration item adds to the sums, and the one
// that completes the set runs the baseline divider once per axis. sample.ready is high
// only while the sequencer is idle; a finished result waits in the output register while the
// next item is accepted, and a second result holds the sequencer until the first is taken.
// Reset clears the sums, count, baselines and calibrated flag; no clearing pass.
module accel_tilt_vibration #(
	parameter int CALIB_SAMPLES   = 100,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	atv_sample_if.sink      sample,
	atv_result_if.source    result
);
	import atv_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam int SH    = 16 - ANGLE_FRAC_BITS;
	localparam logic signed [31:0] RND       = 32'sd1 <<< (SH - 1);
	localparam logic signed [31:0] ROLL_LIM  = 32'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic signed [31:0] PITCH_LIM = 32'sd90 <<< ANGLE_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Rounds a Q16 degree angle to the output scale and clamps it to +-lim.
	function automatic logic signed [31:0] angle_fix(input logic signed [Z_W-1:0] z,
			input logic signed [31:0] lim);
		logic signed [31:0] r;
		r = (32'(z) + RND) >>> SH;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	atv_state_t state_q, state_d;

	logic                    op_q;
	logic signed [IN_W-1:0]  in_q [3];
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [IN_W-1:0]  base_q [3];
	logic [CNT_W-1:0]        count_q;
	logic                    done_flag_q;
	logic [1:0]              axis_q;
	logic [1:0]              sq_idx_q;
	logic [PROD_W-1:0]       prod_q;
	logic [ACC_W-1:0]        acc_q;
	logic [MAG_W-1:0]        mag_q;
	logic [ROOT_W-1:0]       norm_q;
	logic signed [ROLL_W-1:0] roll_q;

	logic                    out_valid_q;
	logic signed [DELTA_W-1:0] out_dx_q, out_dy_q, out_dz_q;
	logic [MAG_W-1:0]        out_mag_q;
	logic signed [ROLL_W-1:0] out_roll_q;
	logic signed [PITCH_W-1:0] out_pitch_q;
	logic                    out_cal_q;

	logic in_fire, last_cal, out_free;
	logic div_start, sqrt_start, cordic_start;
	unit_stat_t div_stat, sqrt_stat, cordic_stat;
	logic [SUM_W-1:0]        div_dvd, div_quo;
	logic [RAD_W-1:0]        sqrt_rad;
	logic [ROOT_W-1:0]       sqrt_root;
	logic signed [XY_W-1:0]  cor_y, cor_x;
	logic signed [Z_W-1:0]   cor_z;
	logic signed [DELTA_W-1:0] delta [3];
	logic signed [DELTA_W-1:0] mul_op;
	logic signed [SUM_W:0]   sat_sum [3];
	logic signed [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0]        sum_mag;
	logic signed [IN_W-1:0]  mean;
	logic signed [31:0]      roll_fix, pitch_fix;

	assign in_fire  = sample.valid && sample.ready;
	assign last_cal = (CNT_W'(count_q + 1'b1) == CNT_W'(CALIB_SAMPLES));
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			delta[k]   = DELTA_W'(in_q[k]) - DELTA_W'(base_q[k]);
			sat_sum[k] = (SUM_W+1)'(sum_q[k]) + (SUM_W+1)'(in_q[k]);
		end
	end

	// Shared squarer operand: deltas for the magnitude, then raw Y and Z for the norm.
	always_comb begin
		mul_op = '0;
		if (state_q == S_SQ) begin
			case (sq_idx_q)
				2'd0: mul_op = delta[0];
				2'd1: mul_op = delta[1];
				2'd2: mul_op = delta[2];
				default: mul_op = '0;
			endcase
		end else begin
			case (sq_idx_q)
				2'd0: mul_op = DELTA_W'(in_q[1]);
				2'd1: mul_op = DELTA_W'(in_q[2]);
				default: mul_op = '0;
			endcase
		end
	end

	// Baseline is the mean of the sum, rounded half away from zero, clamped to 16 bits.
	always_comb begin
		case (axis_q)
			2'd0: cur_sum = sum_q[0];
			2'd1: cur_sum = sum_q[1];
			default: cur_sum = sum_q[2];
		endcase
		sum_mag = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
		div_dvd = sum_mag + SUM_W'(CALIB_SAMPLES / 2);
		if (cur_sum[SUM_W-1])
			mean = (div_quo > SUM_W'(32768)) ? 16'sh8000 : -$signed(div_quo[IN_W-1:0]);
		else
			mean = (div_quo > SUM_W'(32767)) ? 16'sh7FFF : $signed(div_quo[IN_W-1:0]);
	end

	assign sqrt_rad = (state_q == S_MAG_GO) ? RAD_W'(acc_q) : {acc_q[31:0], 16'h0000};

	always_comb begin
		if (state_q == S_ROLL_GO) begin
			cor_y = $signed({{(XY_W-IN_W-8){in_q[1][IN_W-1]}}, in_q[1], 8'h00});
			cor_x = $signed({{(XY_W-IN_W-8){in_q[2][IN_W-1]}}, in_q[2], 8'h00});
		end else begin
			cor_y = -$signed({{(XY_W-IN_W-8){in_q[0][IN_W-1]}}, in_q[0], 8'h00});
			cor_x = $signed({{(XY_W-ROOT_W){1'b0}}, norm_q});
		end
	end

	assign roll_fix  = angle_fix(cor_z, ROLL_LIM);
	assign pitch_fix = angle_fix(cor_z, PITCH_LIM);

	atv_div #(.DIVISOR(CALIB_SAMPLES)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dvd), .quotient(div_quo), .stat(div_stat)
	);

	atv_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(sqrt_rad), .root(sqrt_root), .stat(sqrt_stat)
	);

	atv_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start),
		.y_in(cor_y), .x_in(cor_x), .z_out(cor_z), .stat(cordic_stat)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (in_fire) state_d = sample.opcode ? S_CAL : S_SQ;
			S_CAL:        state_d = last_cal ? S_DIV_GO : S_IDLE;
			S_DIV_GO:     state_d = S_DIV_WAIT;
			S_DIV_WAIT:   if (div_stat.done) state_d = (axis_q == 2'd2) ? S_IDLE : S_DIV_GO;
			S_SQ:         if (sq_idx_q == 2'd3) state_d = S_MAG_GO;
			S_MAG_GO:     state_d = S_MAG_WAIT;
			S_MAG_WAIT:   if (sqrt_stat.done) state_d = S_ROLL_GO;
			S_ROLL_GO:    state_d = S_ROLL_WAIT;
			S_ROLL_WAIT:  if (cordic_stat.done) state_d = S_NSQ;
			S_NSQ:        if (sq_idx_q == 2'd2) state_d = S_NORM_GO;
			S_NORM_GO:    state_d = S_NORM_WAIT;
			S_NORM_WAIT:  if (sqrt_stat.done) state_d = S_PITCH_GO;
			S_PITCH_GO:   state_d = S_PITCH_WAIT;
			S_PITCH_WAIT: if (cordic_stat.done) state_d = S_DONE;
			S_DONE:       if (out_free) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		cordic_start = 1'b0;
		sample.ready = 1'b0;
		case (state_q)
			S_IDLE:     sample.ready = 1'b1;
			S_DIV_GO:   div_start = 1'b1;
			S_MAG_GO:   sqrt_start = 1'b1;
			S_NORM_GO:  sqrt_start = 1'b1;
			S_ROLL_GO:  cordic_start = 1'b1;
			S_PITCH_GO: cordic_start = 1'b1;
			default:    sample.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done_flag_q <= 1'b0;
			axis_q      <= '0;
			sq_idx_q    <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k]  <= '0;
				base_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE || state_q == S_ROLL_WAIT)
				sq_idx_q <= '0;
			else if (state_q == S_SQ || state_q == S_NSQ)
				sq_idx_q <= sq_idx_q + 2'd1;
			if (state_q == S_CAL) begin
				count_q <= last_cal ? '0 : CNT_W'(count_q + 1'b1);
				for (int k = 0; k < 3; k++) begin
					if (sat_sum[k][SUM_W] != sat_sum[k][SUM_W-1])
						sum_q[k] <= sat_sum[k][SUM_W] ? SUM_MIN : SUM_MAX;
					else
						sum_q[k] <= sat_sum[k][SUM_W-1:0];
				end
			end
			if (state_q == S_DIV_WAIT && div_stat.done) begin
				case (axis_q)
					2'd0: base_q[0] <= mean;
					2'd1: base_q[1] <= mean;
					default: base_q[2] <= mean;
				endcase
				if (axis_q == 2'd2) begin
					axis_q      <= '0;
					done_flag_q <= 1'b1;
					for (int k = 0; k < 3; k++)
						sum_q[k] <= '0;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= sample.opcode;
			in_q[0]  <= sample.acc_x;
			in_q[1]  <= sample.acc_y;
			in_q[2]  <= sample.acc_z;
		end
		if (state_q == S_IDLE || state_q == S_ROLL_WAIT) begin
			prod_q <= '0;
			acc_q  <= '0;
		end else if (state_q == S_SQ || state_q == S_NSQ) begin
			prod_q <= PROD_W'(mul_op * mul_op);
			acc_q  <= acc_q + ACC_W'(prod_q);
		end
		if (state_q == S_MAG_WAIT && sqrt_stat.done)
			mag_q <= sqrt_root[MAG_W-1:0];
		if (state_q == S_NORM_WAIT && sqrt_stat.done)
			norm_q <= sqrt_root;
		if (state_q == S_ROLL_WAIT && cordic_stat.done)
			roll_q <= roll_fix[ROLL_W-1:0];
		if (state_q == S_DONE && out_free) begin
			out_dx_q    <= delta[0];
			out_dy_q    <= delta[1];
			out_dz_q    <= delta[2];
			out_mag_q   <= mag_q;
			out_roll_q  <= roll_q;
			out_pitch_q <= pitch_fix[PITCH_W-1:0];
			out_cal_q   <= done_flag_q && !op_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.delta_x       = out_dx_q;
	assign result.delta_y       = out_dy_q;
	assign result.delta_z       = out_dz_q;
	assign result.magnitude     = out_mag_q;
	assign result.roll_angle    = out_roll_q;
	assign result.pitch_angle   = out_pitch_q;
	assign result.is_calibrated = out_cal_q;
endmodule
`default_nettype wire

// ===== rtl/atv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atv_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [16:0] delta_x,
	input wire logic signed [16:0] delta_y,
	input wire logic signed [16:0] delta_z,
	input wire logic [16:0]       magnitude
);
	logic signed [17:0] mag_s, dx_s, dy_s, dz_s;

	assign mag_s = $signed({1'b0, magnitude});
	assign dx_s  = 18'(delta_x);
	assign dy_s  = 18'(delta_y);
	assign dz_s  = 18'(delta_z);

	// A result waiting for its sink keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(delta_x))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	// The norm is never smaller than any single component.
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mag_s >= dx_s && mag_s >= -dx_s && mag_s >= dy_s &&
			mag_s >= -dy_s && mag_s >= dz_s && mag_s >= -dz_s)
		else $error("magnitude below a delta");
endmodule

bind accel_tilt_vibration atv_checker u_atv_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(sample.valid), .in_ready(sample.ready),
	.out_valid(result.valid), .out_ready(result.ready),
	.delta_x(result.delta_x), .delta_y(result.delta_y), .delta_z(result.delta_z),
	.magnitude(result.magnitude)
);
`default_nettype wire

// ===== verif/accel_tilt_vibration_test.sv =====
`timescale 1ns / 1ps
module accel_tilt_vibration_test;
	import atv_pkg::*;

	localparam int CALIB_N   = 100;
	localparam int FRAC_BITS = 7;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLDOFF_AT = 700;
	localparam int HOLDOFF_CYCLES = 400;

	localparam bit OP_MEASURE = 1'b0;
	localparam bit OP_CALIB   = 1'b1;

	// Arctangent of 2^-i in Q16 degrees, the same rotation steps the block uses.
	localparam longint ATAN_STEP[CORDIC_ITERS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	typedef struct {
		bit                 opcode;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	typedef struct {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] dz;
		logic [16:0]        mag;
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic               cal;
	} pose_t;

	logic clk;
	logic arst_n;

	atv_sample_if smp();
	atv_result_if res();

	accel_tilt_vibration u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res)
	);

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Items waiting to be offered, and poses the block still owes us.
	sample_t pending_samples[$];
	pose_t   owed_poses[$];

	// Our own copy of the calibration state.
	longint acc_sum_x, acc_sum_y, acc_sum_z;
	int     calib_count;
	longint base_x, base_y, base_z;
	bit     calibrated;

	int  accepted_cnt;
	int  mismatches;
	bit  offering;
	int  src_idle_pct;
	int  snk_idle_pct;
	int  hold_left;
	bit  hold_done;

	// Sums saturate at the 24-bit signed limits.
	function automatic longint sat24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	// Mean of a full set, rounded with ties away from zero.
	function automatic longint set_mean(longint s);
		longint m;
		longint q;
		m = (s < 0) ? -s : s;
		q = (m + CALIB_N / 2) / CALIB_N;
		if (s < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q;
	endfunction

	// Integer square root, rounded to nearest.
	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned rem;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		rem = v;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (v - r * r > r)
			r = r + 1;
		return r;
	endfunction

	// Vectoring CORDIC; returns the angle of (x, y) in Q16 degrees.
	function automatic longint tilt_atan2(longint y, longint x);
		longint a;
		longint t;
		longint sx;
		longint sy;
		if (x == 0 && y == 0)
			return 0;
		a = 0;
		// A left-half vector is first turned by a quarter so the loop converges.
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; a = longint'(90 * 65536);
			end else begin
				t = x; x = -y; y = t; a = -longint'(90 * 65536);
			end
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y >= 0) begin
				x = x + sx; y = y - sy; a = a + ATAN_STEP[i];
			end else begin
				x = x - sx; y = y + sy; a = a - ATAN_STEP[i];
			end
		end
		return a;
	endfunction

	// Round the Q16 angle half up to the output fraction, then clamp.
	function automatic longint to_angle_units(longint a, longint limit_deg);
		longint r;
		longint lim;
		r = (a + (64'sd1 <<< (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
		lim = limit_deg <<< FRAC_BITS;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	// Apply one accepted item to our state; a measure item yields a pose.
	task automatic track_sample(input sample_t s);
		longint ax, ay, az, ddx, ddy, ddz, syv, szv, norm;
		pose_t p;
		ax = longint'(s.x);
		ay = longint'(s.y);
		az = longint'(s.z);
		if (s.opcode == OP_CALIB) begin
			acc_sum_x = sat24(acc_sum_x + ax);
			acc_sum_y = sat24(acc_sum_y + ay);
			acc_sum_z = sat24(acc_sum_z + az);
			calib_count++;
			if (calib_count >= CALIB_N) begin
				base_x = set_mean(acc_sum_x);
				base_y = set_mean(acc_sum_y);
				base_z = set_mean(acc_sum_z);
				acc_sum_x = 0;
				acc_sum_y = 0;
				acc_sum_z = 0;
				calib_count = 0;
				calibrated = 1'b1;
			end
		end else begin
			ddx = ax - base_x;
			ddy = ay - base_y;
			ddz = az - base_z;
			p.dx = 17'(ddx);
			p.dy = 17'(ddy);
			p.dz = 17'(ddz);
			p.mag = 17'(root_round(ddx * ddx + ddy * ddy + ddz * ddz));
			syv = ay * 256;
			szv = az * 256;
			p.roll = 16'(to_angle_units(tilt_atan2(syv, szv), 180));
			norm = root_round(syv * syv + szv * szv);
			p.pitch = 15'(to_angle_units(tilt_atan2(-ax * 256, norm), 90));
			p.cal = calibrated;
			owed_poses.push_back(p);
		end
	endtask

	task automatic add_sample(input bit op, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z);
		sample_t s;
		s.opcode = op;
		s.x = x;
		s.y = y;
		s.z = z;
		pending_samples.push_back(s);
	endtask

	// Mostly uniform, with the rails and zero showing up often.
	function automatic logic [15:0] pick_axis();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// A value scattered around a center, as a resting sensor produces.
	function automatic logic [15:0] near(input int center, input int spread);
		int v;
		v = center + $urandom_range(2 * spread) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// Idle mix changes with progress: none, sender only, receiver only, both.
	always @(posedge clk) begin
		case ((accepted_cnt / 120) % 4)
			0: begin src_idle_pct <= 0;  snk_idle_pct <= 0;  end
			1: begin src_idle_pct <= 56; snk_idle_pct <= 0;  end
			2: begin src_idle_pct <= 0;  snk_idle_pct <= 56; end
			default: begin src_idle_pct <= 24; snk_idle_pct <= 24; end
		endcase
	end

	// An item leaves the queue at the edge where the block takes it.
	always @(posedge clk) begin
		if (arst_n && smp.valid && smp.ready) begin
			track_sample(pending_samples.pop_front());
			accepted_cnt++;
			offering = 1'b0;
		end
	end

	// Driver: once an item is offered it is held until taken.
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				smp.valid  <= 1'b1;
				smp.opcode <= pending_samples[0].opcode;
				smp.acc_x  <= pending_samples[0].x;
				smp.acc_y  <= pending_samples[0].y;
				smp.acc_z  <= pending_samples[0].z;
				offering = 1'b1;
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	// Receiver ready; once in the run it holds off long enough to back up the block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted_cnt >= HOLDOFF_AT) begin
				hold_done = 1'b1;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Monitor: each taken result is checked against the oldest owed pose.
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && res.valid && res.ready) begin
			if (owed_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: dx=%0d dy=%0d dz=%0d", res.delta_x,
						res.delta_y, res.delta_z);
			end else begin
				e = owed_poses.pop_front();
				if (res.delta_x !== e.dx || res.delta_y !== e.dy || res.delta_z !== e.dz ||
					res.magnitude !== e.mag || res.roll_angle !== e.roll ||
					res.pitch_angle !== e.pitch || res.is_calibrated !== e.cal) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected d=(%0d,%0d,%0d) mag=%0d roll=%0d pitch=%0d cal=%0b",
							e.dx, e.dy, e.dz, e.mag, e.roll, e.pitch, e.cal);
						$display("          got      d=(%0d,%0d,%0d) mag=%0d roll=%0d pitch=%0d cal=%0b",
							res.delta_x, res.delta_y, res.delta_z, res.magnitude,
							res.roll_angle, res.pitch_angle, res.is_calibrated);
					end
				end
			end
		end
	end

	// A hung block must still end the run.
	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int made;
		int r;
		int cx, cy, cz, spread;
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.opcode = OP_MEASURE;
		smp.acc_x = '0;
		smp.acc_y = '0;
		smp.acc_z = '0;
		res.ready = 1'b0;
		acc_sum_x = 0; acc_sum_y = 0; acc_sum_z = 0;
		calib_count = 0;
		base_x = 0; base_y = 0; base_z = 0;
		calibrated = 1'b0;
		accepted_cnt = 0;
		mismatches = 0;
		offering = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_left = 0;
		hold_done = 1'b0;

		// Measures before any calibration: deltas equal the raw sample. The zero vector
		// checks the both-operands-zero angle case, and the rails check the widest
		// deltas and the pre-rotation of left-half vectors.
		add_sample(OP_MEASURE, 16'h0000, 16'h0000, 16'h0000);
		add_sample(OP_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_sample(OP_MEASURE, 16'h8000, 16'h8000, 16'h8000);
		add_sample(OP_MEASURE, 16'h0000, 16'h4000, 16'h8000);
		add_sample(OP_MEASURE, 16'h0000, 16'hC000, 16'h8000);
		add_sample(OP_MEASURE, 16'h8000, 16'h0000, 16'h0000);
		add_sample(OP_MEASURE, 16'h7FFF, 16'h0000, 16'h0000);
		add_sample(OP_MEASURE, 16'h0000, 16'h0000, 16'h4000);
		add_sample(OP_MEASURE, 16'h0000, 16'h8000, 16'h0000);
		add_sample(OP_MEASURE, 16'h5555, 16'hAAAA, 16'h0001);
		// A full set at the negative rail pulls the baselines to the bottom, so a
		// positive-rail measure then gives the largest possible deltas.
		for (int i = 0; i < CALIB_N; i++)
			add_sample(OP_CALIB, 16'h8000, 16'h8000, 16'h8000);
		add_sample(OP_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_sample(OP_MEASURE, 16'h8000, 16'h8000, 16'h8000);
		// A set whose X and Y means land on a half, to check rounding away from zero.
		for (int i = 0; i < CALIB_N; i++)
			add_sample(OP_CALIB, (i < 50) ? 16'hFFFF : 16'h0000,
				(i < 50) ? 16'h0001 : 16'h0000, 16'h7FFF);
		add_sample(OP_MEASURE, 16'h0000, 16'h0000, 16'h0000);
		add_sample(OP_MEASURE, 16'h1234, 16'hEDCB, 16'h4000);

		// Random part: mostly measures, with whole calibration sets of a resting
		// sensor and scattered partial sets that carry the count across measures.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 4) begin
				cx = $signed(16'(pick_axis()));
				cy = $signed(16'(pick_axis()));
				cz = $signed(16'(pick_axis()));
				spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(400);
				for (int i = 0; i < CALIB_N; i++)
					add_sample(OP_CALIB, near(cx, spread), near(cy, spread),
						near(cz, spread));
				made += CALIB_N;
			end else if (r < 20) begin
				repeat ($urandom_range(1, 5)) begin
					add_sample(OP_CALIB, pick_axis(), pick_axis(), pick_axis());
					made++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					add_sample(OP_MEASURE, pick_axis(), pick_axis(), pick_axis());
					made++;
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_samples.size() > 0 || offering)
			@(posedge clk);
		while (owed_poses.size() > 0)
			@(posedge clk);
		// Room for a set-closing item still dividing and any stray result.
		repeat (300) @(posedge clk);

		if (mismatches == 0 && owed_poses.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
